@@ design/eabb_pkg.sv @@
// Package for the elliptic arc bounding box core.
// Holds the shape codes and quadrant codes shared by the interfaces and the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eabb_pkg;

    typedef logic [1:0] shape_t;
    typedef logic [1:0] quad_t;

    localparam shape_t SHAPE_ARC   = 2'd0;
    localparam shape_t SHAPE_CHORD = 2'd1;
    localparam shape_t SHAPE_PIE   = 2'd2;

    localparam quad_t QUAD_POS_X = 2'd0;
    localparam quad_t QUAD_NEG_Y = 2'd1;
    localparam quad_t QUAD_NEG_X = 2'd2;
    localparam quad_t QUAD_POS_Y = 2'd3;

    localparam int FIFO_DEPTH = 2;

endpackage
`default_nettype wire

@@ design/eabb_if.sv @@
// Valid/ready channel interfaces for command words and result words.
// Depends on eabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface eabb_cmd_if #(parameter int COORD_BITS = 16);
    import eabb_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] box_x0;
    logic signed [COORD_BITS-1:0] box_y0;
    logic signed [COORD_BITS-1:0] box_x1;
    logic signed [COORD_BITS-1:0] box_y1;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    shape_t shape_kind;

    modport source (output valid, box_x0, box_y0, box_x1, box_y1, start_x, start_y,
                    end_x, end_y, shape_kind, input ready);
    modport sink (input valid, box_x0, box_y0, box_x1, box_y1, start_x, start_y,
                  end_x, end_y, shape_kind, output ready);
endinterface

interface eabb_res_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic valid_res;
    logic signed [COORD_BITS-1:0] bound_left;
    logic signed [COORD_BITS-1:0] bound_top;
    logic signed [COORD_BITS-1:0] bound_right;
    logic signed [COORD_BITS-1:0] bound_bottom;

    modport source (output valid, valid_res, bound_left, bound_top, bound_right,
                    bound_bottom, input ready);
    modport sink (input valid, valid_res, bound_left, bound_top, bound_right,
                  bound_bottom, output ready);
endinterface
`default_nettype wire

@@ design/eabb_front.sv @@
// Front end: accepts command words, orders the box and finds centre and half-axes.
// Depends on eabb_pkg and eabb_cmd_if; feeds eabb_fifo.
`timescale 1ns / 1ps
`default_nettype none
module eabb_front #(
    parameter int W = 16,
    parameter int PLW = 12 * W + 1
) (
    eabb_cmd_if.sink         cmd,
    input  logic             fifo_full,
    output logic             push,
    output logic [PLW-1:0]   push_data
);
    import eabb_pkg::*;

    logic                 degen;
    logic signed [W-1:0]  lo_x, hi_x, lo_y, hi_y, rr, bb, xc, yc;
    logic signed [W:0]    sum_x, sum_y, adj_x, adj_y;
    logic [W-1:0]         wid_x, wid_y;
    logic [W-2:0]         ha, hb;

    assign cmd.ready = !fifo_full;
    assign push      = cmd.valid && !fifo_full;

    always_comb
    begin
        degen = (cmd.box_x0 == cmd.box_x1) || (cmd.box_y0 == cmd.box_y1);
        lo_x  = (cmd.box_x0 < cmd.box_x1) ? cmd.box_x0 : cmd.box_x1;
        hi_x  = (cmd.box_x0 < cmd.box_x1) ? cmd.box_x1 : cmd.box_x0;
        lo_y  = (cmd.box_y0 < cmd.box_y1) ? cmd.box_y0 : cmd.box_y1;
        hi_y  = (cmd.box_y0 < cmd.box_y1) ? cmd.box_y1 : cmd.box_y0;
        rr    = hi_x - W'(1);
        bb    = hi_y - W'(1);
        sum_x = $signed({lo_x[W-1], lo_x}) + $signed({rr[W-1], rr}) + $signed((W+1)'(1));
        sum_y = $signed({lo_y[W-1], lo_y}) + $signed({bb[W-1], bb}) + $signed((W+1)'(1));
        // Halving truncates toward zero.
        adj_x = sum_x + $signed({{W{1'b0}}, sum_x[W]});
        adj_y = sum_y + $signed({{W{1'b0}}, sum_y[W]});
        xc    = adj_x[W:1];
        yc    = adj_y[W:1];
        wid_x = W'(hi_x - lo_x);
        wid_y = W'(hi_y - lo_y);
        ha    = wid_x[W-1:1];
        hb    = wid_y[W-1:1];
    end

    assign push_data = {degen, cmd.shape_kind, lo_x, lo_y, rr, bb, xc, yc, ha, hb,
                        cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y};

endmodule
`default_nettype wire

@@ design/eabb_fifo.sv @@
// Short queue between front end and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module eabb_fifo #(
    parameter int DW = 8,
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          full,
    output logic          empty
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   mem_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ design/eabb_back.sv @@
// Back end: direction setup, exact projection by bit-per-stage root search,
// angle sweep and final bounds. Depends on eabb_pkg and eabb_res_if.
`timescale 1ns / 1ps
`default_nettype none
module eabb_back #(
    parameter int W = 16,
    parameter int PLW = 12 * W + 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fifo_empty,
    input  logic [PLW-1:0] fifo_data,
    output logic           fifo_pop,
    eabb_res_if.source     res
);
    import eabb_pkg::*;

    localparam int MW = W + 1;
    localparam int SW = 2 * W + 2;
    localparam int AW = 2 * W;
    localparam int PW = 4 * W + 1;
    localparam int NS = W - 1;

    typedef struct packed {
        logic                 degen;
        shape_t               shape;
        logic signed [W-1:0]  l;
        logic signed [W-1:0]  t;
        logic signed [W-1:0]  r;
        logic signed [W-1:0]  b;
        logic signed [W-1:0]  xc;
        logic signed [W-1:0]  yc;
        logic [1:0]           negx;
        logic [1:0]           negy;
        quad_t [1:0]          quad;
        logic [1:0]           axis;
        logic                 less;
    } ctx_t;

    logic                 u_degen;
    shape_t               u_shape;
    logic signed [W-1:0]  u_l, u_t, u_r, u_bot, u_xc, u_yc, u_sx, u_sy, u_ex, u_ey;
    logic [W-2:0]         u_ha, u_hb;
    logic                 en;

    assign {u_degen, u_shape, u_l, u_t, u_r, u_bot, u_xc, u_yc, u_ha, u_hb,
            u_sx, u_sy, u_ex, u_ey} = fifo_data;

    logic                 res_vld_reg;
    assign en       = !res_vld_reg || res.ready;
    assign fifo_pop = en && !fifo_empty;

    // Direction setup.
    logic signed [W-1:0]  pt_x [2];
    logic signed [W-1:0]  pt_y [2];
    logic signed [MW-1:0] dx_c [2];
    logic signed [MW-1:0] dy_c [2];
    logic [MW-1:0]        mx_c [2];
    logic [MW-1:0]        my_c [2];
    quad_t                qd_c [2];

    assign pt_x[0] = u_sx;
    assign pt_x[1] = u_ex;
    assign pt_y[0] = u_sy;
    assign pt_y[1] = u_ey;

    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            dx_c[d] = $signed({pt_x[d][W-1], pt_x[d]}) - $signed({u_xc[W-1], u_xc});
            dy_c[d] = $signed({pt_y[d][W-1], pt_y[d]}) - $signed({u_yc[W-1], u_yc});
            if (dx_c[d] == '0 && dy_c[d] == '0)
            begin
                dx_c[d] = $signed(MW'(1));
            end
            mx_c[d] = dx_c[d][MW-1] ? MW'(-dx_c[d]) : MW'(dx_c[d]);
            my_c[d] = dy_c[d][MW-1] ? MW'(-dy_c[d]) : MW'(dy_c[d]);
            if (dx_c[d] > 0 && dy_c[d] <= 0)
            begin
                qd_c[d] = QUAD_POS_X;
            end
            else if (dx_c[d] <= 0 && dy_c[d] < 0)
            begin
                qd_c[d] = QUAD_NEG_Y;
            end
            else if (dx_c[d] < 0 && dy_c[d] >= 0)
            begin
                qd_c[d] = QUAD_NEG_X;
            end
            else
            begin
                qd_c[d] = QUAD_POS_Y;
            end
        end
    end

    logic          s1_vld_reg;
    ctx_t          s1_ctx_reg;
    logic [W-2:0]  s1_ha_reg, s1_hb_reg;
    logic [MW-1:0] s1_mx_reg [2];
    logic [MW-1:0] s1_my_reg [2];
    logic [MW-1:0] s1_rx_reg [2];
    logic [MW-1:0] s1_ry_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg.degen <= u_degen;
            s1_ctx_reg.shape <= u_shape;
            s1_ctx_reg.l     <= u_l;
            s1_ctx_reg.t     <= u_t;
            s1_ctx_reg.r     <= u_r;
            s1_ctx_reg.b     <= u_bot;
            s1_ctx_reg.xc    <= u_xc;
            s1_ctx_reg.yc    <= u_yc;
            s1_ctx_reg.less  <= 1'b0;
            s1_ha_reg        <= u_ha;
            s1_hb_reg        <= u_hb;
            for (int d = 0; d < 2; d++)
            begin
                s1_ctx_reg.negx[d] <= dx_c[d][MW-1];
                s1_ctx_reg.negy[d] <= dy_c[d][MW-1];
                s1_ctx_reg.quad[d] <= qd_c[d];
                s1_ctx_reg.axis[d] <= qd_c[d][0] ? (mx_c[d] == '0) : (my_c[d] == '0);
                s1_mx_reg[d]       <= mx_c[d];
                s1_my_reg[d]       <= my_c[d];
                s1_rx_reg[d]       <= qd_c[d][0] ? my_c[d] : mx_c[d];
                s1_ry_reg[d]       <= qd_c[d][0] ? mx_c[d] : my_c[d];
            end
        end
    end

    // Squares, half-axis products and cross products for the angle test.
    logic          s2_vld_reg;
    ctx_t          s2_ctx_reg;
    logic [SW-1:0] s2_sqx_reg [2];
    logic [SW-1:0] s2_sqy_reg [2];
    logic [AW-1:0] s2_an_reg [4];
    logic [SW-1:0] s2_pe_reg, s2_ps_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ctx_reg <= s1_ctx_reg;
            for (int d = 0; d < 2; d++)
            begin
                s2_sqx_reg[d] <= SW'(s1_mx_reg[d]) * SW'(s1_mx_reg[d]);
                s2_sqy_reg[d] <= SW'(s1_my_reg[d]) * SW'(s1_my_reg[d]);
                s2_an_reg[2*d]   <= AW'(s1_ha_reg) * AW'(s1_mx_reg[d]);
                s2_an_reg[2*d+1] <= AW'(s1_hb_reg) * AW'(s1_my_reg[d]);
            end
            s2_pe_reg <= SW'(s1_ry_reg[1]) * SW'(s1_rx_reg[0]);
            s2_ps_reg <= SW'(s1_ry_reg[0]) * SW'(s1_rx_reg[1]);
        end
    end

    // Sum of squares, target split into partial products, angle order.
    logic          s3_vld_reg;
    ctx_t          s3_ctx_reg;
    logic [SW-1:0] s3_s_reg [2];
    logic [AW-1:0] s3_hh_reg [4];
    logic [AW-1:0] s3_hl_reg [4];
    logic [AW-1:0] s3_ll_reg [4];
    logic          less_c;

    always_comb
    begin
        if (s2_ctx_reg.quad[1] != s2_ctx_reg.quad[0])
        begin
            less_c = s2_ctx_reg.quad[1] < s2_ctx_reg.quad[0];
        end
        else if (s2_ctx_reg.axis[1])
        begin
            less_c = !s2_ctx_reg.axis[0];
        end
        else if (s2_ctx_reg.axis[0])
        begin
            less_c = 1'b0;
        end
        else
        begin
            less_c = s2_pe_reg < s2_ps_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ctx_reg      <= s2_ctx_reg;
            s3_ctx_reg.less <= less_c;
            for (int d = 0; d < 2; d++)
            begin
                s3_s_reg[d] <= s2_sqx_reg[d] + s2_sqy_reg[d];
            end
            for (int l = 0; l < 4; l++)
            begin
                s3_hh_reg[l] <= AW'(s2_an_reg[l][AW-1:W]) * AW'(s2_an_reg[l][AW-1:W]);
                s3_hl_reg[l] <= AW'(s2_an_reg[l][AW-1:W]) * AW'(s2_an_reg[l][W-1:0]);
                s3_ll_reg[l] <= AW'(s2_an_reg[l][W-1:0]) * AW'(s2_an_reg[l][W-1:0]);
            end
        end
    end

    // Root search pipeline; entry 0 is loaded with the assembled target.
    logic          sr_vld_reg [NS+1];
    ctx_t          sr_ctx_reg [NS+1];
    logic [SW-1:0] sr_s_reg   [NS+1][2];
    logic [PW-1:0] sr_tgt_reg [NS+1][4];
    logic [W-2:0]  sr_q_reg   [NS+1][4];
    logic [PW-1:0] sr_p_reg   [NS+1][4];
    logic [PW-1:0] sr_qs_reg  [NS+1][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_ctx_reg[0] <= s3_ctx_reg;
            sr_s_reg[0]   <= s3_s_reg;
            for (int l = 0; l < 4; l++)
            begin
                sr_tgt_reg[0][l] <= (PW'(s3_hh_reg[l]) << (2 * W))
                                  + (PW'(s3_hl_reg[l]) << (W + 1)) + PW'(s3_ll_reg[l]);
                sr_q_reg[0][l]   <= '0;
                sr_p_reg[0][l]   <= '0;
                sr_qs_reg[0][l]  <= '0;
            end
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_search
        localparam int K = NS - 1 - j;
        logic [PW-1:0] cand [4];
        logic          take [4];

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                cand[l] = sr_p_reg[j][l] + (sr_qs_reg[j][l] << (K + 1))
                        + (PW'(sr_s_reg[j][l/2]) << (2 * K));
                take[l] = cand[l] <= sr_tgt_reg[j][l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_ctx_reg[j+1] <= sr_ctx_reg[j];
                sr_s_reg[j+1]   <= sr_s_reg[j];
                for (int l = 0; l < 4; l++)
                begin
                    sr_tgt_reg[j+1][l] <= sr_tgt_reg[j][l];
                    sr_q_reg[j+1][l]   <= sr_q_reg[j][l] | ((W-1)'(take[l]) << K);
                    sr_p_reg[j+1][l]   <= take[l] ? cand[l] : sr_p_reg[j][l];
                    sr_qs_reg[j+1][l]  <= take[l]
                                        ? sr_qs_reg[j][l] + (PW'(sr_s_reg[j][l/2]) << K)
                                        : sr_qs_reg[j][l];
                end
            end
        end
    end

    // Bounds from the projected points, the swept axes and the pie centre.
    ctx_t                 fc;
    logic signed [MW-1:0] off [4];
    logic signed [MW-1:0] xce, yce, bl, bt, br, bb;
    logic [3:0]           ke;
    logic [3:0]           push_ax;
    logic                 past;

    always_comb
    begin
        fc = sr_ctx_reg[NS];
        for (int l = 0; l < 4; l++)
        begin
            off[l] = $signed(MW'(sr_q_reg[NS][l]));
            if ((l % 2 == 0) ? fc.negx[l/2] : fc.negy[l/2])
            begin
                off[l] = -off[l];
            end
        end
        xce = $signed({fc.xc[W-1], fc.xc});
        yce = $signed({fc.yc[W-1], fc.yc});
        bl  = xce + ((off[0] < off[2]) ? off[0] : off[2]);
        br  = xce + ((off[0] > off[2]) ? off[0] : off[2]);
        bt  = yce + ((off[1] < off[3]) ? off[1] : off[3]);
        bb  = yce + ((off[1] > off[3]) ? off[1] : off[3]);
        ke  = {2'b00, fc.quad[1]} + (fc.less ? 4'd4 : 4'd0);
        push_ax = '0;
        for (int i = 0; i <= 8; i++)
        begin
            past = (4'(i) > {2'b00, fc.quad[0]})
                || ((4'(i) == {2'b00, fc.quad[0]}) && fc.axis[0]);
            if (past && (4'(i) <= ke))
            begin
                push_ax[i % 4] = 1'b1;
            end
        end
        if (push_ax[QUAD_POS_X])
        begin
            br = $signed({fc.r[W-1], fc.r});
        end
        if (push_ax[QUAD_NEG_Y])
        begin
            bt = $signed({fc.t[W-1], fc.t});
        end
        if (push_ax[QUAD_NEG_X])
        begin
            bl = $signed({fc.l[W-1], fc.l});
        end
        if (push_ax[QUAD_POS_Y])
        begin
            bb = $signed({fc.b[W-1], fc.b});
        end
        if (fc.shape == SHAPE_PIE)
        begin
            if (bl > xce)
            begin
                bl = xce;
            end
            else if (br < xce)
            begin
                br = xce;
            end
            if (bt > yce)
            begin
                bt = yce;
            end
            else if (bb < yce)
            begin
                bb = yce;
            end
        end
    end

    logic                valid_res_reg;
    logic signed [W-1:0] left_reg, top_reg, right_reg, bottom_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_res_reg <= !fc.degen;
            left_reg      <= fc.degen ? '0 : W'(bl);
            top_reg       <= fc.degen ? '0 : W'(bt);
            right_reg     <= fc.degen ? '0 : W'(br);
            bottom_reg    <= fc.degen ? '0 : W'(bb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            for (int j = 0; j <= NS; j++)
            begin
                sr_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg    <= !fifo_empty;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            sr_vld_reg[0] <= s3_vld_reg;
            for (int j = 0; j < NS; j++)
            begin
                sr_vld_reg[j+1] <= sr_vld_reg[j];
            end
            res_vld_reg   <= sr_vld_reg[NS];
        end
    end

    assign res.valid        = res_vld_reg;
    assign res.valid_res    = valid_res_reg;
    assign res.bound_left   = left_reg;
    assign res.bound_top    = top_reg;
    assign res.bound_right  = right_reg;
    assign res.bound_bottom = bottom_reg;

endmodule
`default_nettype wire

@@ design/elliptic_arc_bounding_box_core.sv @@
// Throughput: one word per cycle while the result channel is ready; the root search takes one result bit per stage.
// A two-entry queue parts the front end from the stalling back-end pipeline.
// Reset clears all valid flags and queue pointers; datapath registers are not reset.
// Depends on eabb_pkg, eabb_if, eabb_front, eabb_fifo and eabb_back.
`timescale 1ns / 1ps
`default_nettype none
module elliptic_arc_bounding_box_core #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    eabb_cmd_if.sink    cmd,
    eabb_res_if.source  res
);
    import eabb_pkg::*;

    localparam int PLW = 12 * COORD_BITS + 1;

    logic           push, pop, full, empty;
    logic [PLW-1:0] push_data, pop_data;

    eabb_front #(.W(COORD_BITS), .PLW(PLW)) u_front (
        .cmd       (cmd),
        .fifo_full (full),
        .push      (push),
        .push_data (push_data)
    );

    eabb_fifo #(.DW(PLW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    eabb_back #(.W(COORD_BITS), .PLW(PLW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (empty),
        .fifo_data  (pop_data),
        .fifo_pop   (pop),
        .res        (res)
    );

endmodule
`default_nettype wire

@@ design/eabb_checker.sv @@
// Port-level checks on the result channel of the core, and the bind that attaches them.
// Depends on elliptic_arc_bounding_box_core.
`timescale 1ns / 1ps
`default_nettype none
module eabb_checker #(
    parameter int W = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input logic                valid_res,
    input logic signed [W-1:0] bound_left,
    input logic signed [W-1:0] bound_top,
    input logic signed [W-1:0] bound_right,
    input logic signed [W-1:0] bound_bottom
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result word dropped while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !valid_res) |-> (bound_left == '0 && bound_top == '0
            && bound_right == '0 && bound_bottom == '0))
        else $error("degenerate box gave nonzero bounds");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> ($stable(valid_res) && $stable(bound_left)
            && $stable(bound_top) && $stable(bound_right) && $stable(bound_bottom)))
        else $error("result word changed while stalled");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !res_valid)
        else $error("result word right after reset");

endmodule

bind elliptic_arc_bounding_box_core eabb_checker #(.W(COORD_BITS)) u_eabb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .valid_res    (res.valid_res),
    .bound_left   (res.bound_left),
    .bound_top    (res.bound_top),
    .bound_right  (res.bound_right),
    .bound_bottom (res.bound_bottom)
);
`default_nettype wire

@@ sim/eabb_tb_if.sv @@
// Channel interfaces used by the testbench are the design's own (eabb_if.sv).
// This file holds the word types the testbench keeps for commands and results.
// Depends on eabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
package eabb_tb_pkg;
    import eabb_pkg::*;

    typedef struct {
        logic signed [15:0] x0, y0, x1, y1, sx, sy, ex, ey;
        shape_t             kind;
    } cmd_word_t;

    typedef struct {
        logic               ok;
        logic signed [15:0] left, top, right, bottom;
    } bound_word_t;
endpackage
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for the elliptic arc bounding box core: drives command words, predicts
// each bounding box with exact integer geometry and checks every result word.
// Depends on eabb_pkg, eabb_if, eabb_tb_pkg and the core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import eabb_pkg::*;
    import eabb_tb_pkg::*;

    localparam int LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    always #6 clk = ~clk;

    eabb_cmd_if #(16) cmd ();
    eabb_res_if #(16) res ();

    elliptic_arc_bounding_box_core #(.COORD_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .res(res.source)
    );

    bound_word_t expected_boxes[$];
    int errors = 0;
    int checked = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int degenerate_seen = 0;
    int pies_seen = 0;

    typedef struct {
        longint offx, offy;
        int     quad;
        bit     on_axis;
        longint rx, ry;
    } ray_t;

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // floor(half * num / sqrt(s)) by binary search with exact 128-bit products
    function automatic longint project_axis(longint half, longint num, longint s);
        longint lo, hi, mid;
        logic [127:0] rhs, lhs;
        lo = 0;
        hi = half;
        rhs = 128'(half * half) * 128'(num * num);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 128'(mid * mid) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic ray_t cast_ray(longint dx, longint dy, longint a, longint b);
        ray_t r;
        longint s, u, v;
        if (dx == 0 && dy == 0)
            dx = 1;
        s = dx * dx + dy * dy;
        r.offx = project_axis(a, iabs(dx), s);
        r.offy = project_axis(b, iabs(dy), s);
        if (dx < 0)
            r.offx = -r.offx;
        if (dy < 0)
            r.offy = -r.offy;
        u = dx;
        v = -dy;
        if (u > 0 && v >= 0)
        begin
            r.quad = QUAD_POS_X; r.rx = iabs(u); r.ry = iabs(v);
        end
        else if (u <= 0 && v > 0)
        begin
            r.quad = QUAD_NEG_Y; r.rx = iabs(v); r.ry = iabs(u);
        end
        else if (u < 0 && v <= 0)
        begin
            r.quad = QUAD_NEG_X; r.rx = iabs(u); r.ry = iabs(v);
        end
        else
        begin
            r.quad = QUAD_POS_Y; r.rx = iabs(v); r.ry = iabs(u);
        end
        r.on_axis = (r.ry == 0);
        return r;
    endfunction

    function automatic bit angle_below(ray_t e, ray_t s);
        if (e.quad != s.quad)
            return e.quad < s.quad;
        if (e.on_axis)
            return !s.on_axis;
        if (s.on_axis)
            return 0;
        return e.ry * s.rx < s.ry * e.rx;
    endfunction

    function automatic bound_word_t arc_bounds(cmd_word_t c);
        bound_word_t w;
        longint l, t, r, b, xc, yc, ha, hb, bl, bt, br, bb, tmp;
        ray_t rs, re;
        int ke;
        bit past;
        w = '{ok: 0, left: 0, top: 0, right: 0, bottom: 0};
        l = c.x0; t = c.y0; r = c.x1; b = c.y1;
        if (l == r || t == b)
            return w;
        if (l > r)
        begin
            tmp = l; l = r; r = tmp;
        end
        if (t > b)
        begin
            tmp = t; t = b; b = tmp;
        end
        r--;
        b--;
        xc = (l + r + 1) / 2;
        yc = (t + b + 1) / 2;
        ha = (r - l + 1) / 2;
        hb = (b - t + 1) / 2;
        rs = cast_ray(longint'(c.sx) - xc, longint'(c.sy) - yc, ha, hb);
        re = cast_ray(longint'(c.ex) - xc, longint'(c.ey) - yc, ha, hb);
        bl = xc + (rs.offx < re.offx ? rs.offx : re.offx);
        br = xc + (rs.offx > re.offx ? rs.offx : re.offx);
        bt = yc + (rs.offy < re.offy ? rs.offy : re.offy);
        bb = yc + (rs.offy > re.offy ? rs.offy : re.offy);
        ke = re.quad + (angle_below(re, rs) ? 4 : 0);
        for (int i = 0; i <= 8; i++)
        begin
            past = i > rs.quad || (i == rs.quad && rs.on_axis);
            if (past && i <= ke)
            begin
                case (i % 4)
                    QUAD_POS_X: br = r;
                    QUAD_NEG_Y: bt = t;
                    QUAD_NEG_X: bl = l;
                    default:    bb = b;
                endcase
            end
        end
        if (c.kind == SHAPE_PIE)
        begin
            if (bl > xc)
                bl = xc;
            else if (br < xc)
                br = xc;
            if (bt > yc)
                bt = yc;
            else if (bb < yc)
                bb = yc;
        end
        w.ok = 1;
        w.left = 16'(bl);
        w.top = 16'(bt);
        w.right = 16'(br);
        w.bottom = 16'(bb);
        return w;
    endfunction

    typedef struct {
        cmd_word_t   c;
        bit          typed;
        bound_word_t want;
    } stim_row_t;

    localparam logic signed [15:0] MN = -16'sd32768;
    localparam logic signed [15:0] MX = 16'sd32767;
    localparam bound_word_t NONE = '{ok: 0, left: 0, top: 0, right: 0, bottom: 0};

    stim_row_t directed[20] = '{
        '{'{0, 0, 0, 10, 5, 5, 1, 1, SHAPE_ARC}, 1, NONE},
        '{'{3, 7, 9, 7, 1, 2, 3, 4, SHAPE_PIE}, 1, NONE},
        '{'{MN, MN, MN, MX, 0, 0, 0, 0, SHAPE_CHORD}, 1, NONE},
        '{'{MN, MN, MX, MX, MX, 0, 0, MN, SHAPE_ARC}, 0, NONE},
        '{'{MX, MX, MN, MN, MN, MX, MX, MN, SHAPE_PIE}, 0, NONE},
        '{'{MN, MX, MX, MN, MX, MX, MN, MN, SHAPE_CHORD}, 0, NONE},
        '{'{0, 0, 10, 10, 5, 5, 5, 5, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 5, 5, 5, 5, SHAPE_PIE}, 0, NONE},
        '{'{0, 0, 10, 10, 9, 5, 9, 5, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 9, 5, 1, 5, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 1, 5, 9, 5, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 5, 1, 5, 9, SHAPE_PIE}, 0, NONE},
        '{'{0, 0, 10, 10, 5, 9, 5, 1, SHAPE_CHORD}, 0, NONE},
        '{'{0, 0, 10, 10, 9, 2, 8, 1, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 8, 1, 9, 2, SHAPE_ARC}, 0, NONE},
        '{'{0, 0, 10, 10, 9, 8, 8, 9, SHAPE_PIE}, 0, NONE},
        '{'{0, 0, 1, 1, 0, 0, 1, 1, SHAPE_PIE}, 0, NONE},
        '{'{-5, -5, -4, 20, 7, -3, -9, 2, 2'd3}, 0, NONE},
        '{'{100, 200, -300, -50, 0, 0, MX, MX, 2'd3}, 0, NONE},
        '{'{1, 1, 2, 2, 1, 1, 1, 1, SHAPE_ARC}, 0, NONE}
    };

    function automatic logic signed [15:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? MX : MN;
            default: return 16'(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic cmd_word_t rnd_cmd();
        cmd_word_t c;
        c.x0 = rnd_coord(); c.y0 = rnd_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            c.x1 = c.x0 + 16'($urandom_range(0, 6)) - 16'sd3;
            c.y1 = c.y0 + 16'($urandom_range(0, 6)) - 16'sd3;
        end
        else
        begin
            c.x1 = rnd_coord(); c.y1 = rnd_coord();
        end
        c.sx = rnd_coord(); c.sy = rnd_coord();
        c.ex = rnd_coord(); c.ey = rnd_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            c.sx = 16'((longint'(c.x0) + c.x1) / 2);
            c.sy = 16'((longint'(c.y0) + c.y1) / 2);
        end
        c.kind = shape_t'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic send_word(cmd_word_t c);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            cmd.valid <= 0;
            @(posedge clk);
        end
        cmd.valid <= 1;
        cmd.box_x0 <= c.x0; cmd.box_y0 <= c.y0;
        cmd.box_x1 <= c.x1; cmd.box_y1 <= c.y1;
        cmd.start_x <= c.sx; cmd.start_y <= c.sy;
        cmd.end_x <= c.ex; cmd.end_y <= c.ey;
        cmd.shape_kind <= c.kind;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic issue(cmd_word_t c, bit typed, bound_word_t want);
        bound_word_t p;
        p = arc_bounds(c);
        if (typed && p != want)
            $error("typed row disagrees with prediction");
        expected_boxes.push_back(typed ? want : p);
        if (!p.ok)
            degenerate_seen++;
        if (c.kind == SHAPE_PIE)
            pies_seen++;
        send_word(c);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n)
            res.ready <= !(recv_idle > 0 && $urandom_range(0, 99) < recv_idle);
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                $error("result word with no command pending");
                errors++;
            end
            else
            begin
                bound_word_t w;
                w = expected_boxes.pop_front();
                checked++;
                if (res.valid_res !== w.ok)
                begin
                    $error("valid_res expected %0d got %0d", w.ok, res.valid_res);
                    errors++;
                end
                if (res.bound_left !== w.left)
                begin
                    $error("bound_left expected %0d got %0d", w.left, res.bound_left);
                    errors++;
                end
                if (res.bound_top !== w.top)
                begin
                    $error("bound_top expected %0d got %0d", w.top, res.bound_top);
                    errors++;
                end
                if (res.bound_right !== w.right)
                begin
                    $error("bound_right expected %0d got %0d", w.right, res.bound_right);
                    errors++;
                end
                if (res.bound_bottom !== w.bottom)
                begin
                    $error("bound_bottom expected %0d got %0d", w.bottom,
                           res.bound_bottom);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int spins;
        cmd.valid = 0;
        cmd.box_x0 = 0; cmd.box_y0 = 0; cmd.box_x1 = 0; cmd.box_y1 = 0;
        cmd.start_x = 0; cmd.start_y = 0; cmd.end_x = 0; cmd.end_y = 0;
        cmd.shape_kind = SHAPE_ARC;
        res.ready = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i])
            issue(directed[i].c, directed[i].typed, directed[i].want);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = phase == 0 ? 25 : phase == 1 ? 82 : 0;
            recv_idle = phase == 0 ? 82 : phase == 1 ? 25 : 0;
            for (int n = 0; n < 250; n++)
                issue(rnd_cmd(), 0, NONE);
        end
        cmd.valid <= 0;
        recv_idle = 0;
        spins = 0;
        while (expected_boxes.size() > 0 && spins < 10000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (40) @(posedge clk);
        $display("Checked %0d result words, %0d with a degenerate box and %0d pies.",
                 checked, degenerate_seen, pies_seen);
        if (expected_boxes.size() > 0)
        begin
            $error("%0d result words never arrived", expected_boxes.size());
            errors++;
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
design/eabb_pkg.sv
design/eabb_if.sv
design/eabb_front.sv
design/eabb_fifo.sv
design/eabb_back.sv
design/elliptic_arc_bounding_box_core.sv
design/eabb_checker.sv
sim/eabb_tb_if.sv
sim/testbench.sv
